// ===== hdl/espc_pkg.sv =====
// Shared types and constants for the encoder speed PI controller.
// No dependencies; every other file imports this package.
package espc_pkg;

    localparam int MOTOR_COUNT = 2;

    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 24;
    localparam int COUNT_W     = 16;
    localparam int GAIN_W      = 16;
    localparam int SPEED_W     = 16;
    localparam int SCALE_W     = 24;
    localparam int DUTY_FRAC_W = 8;
    localparam int DUTY_W      = 20;
    localparam int DUTY_OUT_W  = 12;
    localparam int ERR_W       = 18;
    localparam int DERR_W      = 19;
    localparam int PI_HI_W     = 21;

    localparam logic [DUTY_OUT_W-1:0] DUTY_LIMIT  = 12'd4000;
    localparam logic [DUTY_W-1:0]     DUTY_MAX_Q8 = {DUTY_LIMIT, 8'd0};
    localparam logic [SPEED_W-1:0]    SPEED_MAX   = 16'hFFFF;

    localparam logic [GAIN_W-1:0]  PROP_GAIN_RST   = 16'd128;
    localparam logic [GAIN_W-1:0]  INTEG_GAIN_RST  = 16'd102;
    localparam logic [SCALE_W-1:0] SPEED_SCALE_RST = 24'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PROP_GAIN      = 3'd0,
        CFG_INTEG_GAIN     = 3'd1,
        CFG_TARGET_SPEED_A = 3'd2,
        CFG_TARGET_SPEED_B = 3'd3,
        CFG_SPEED_SCALE    = 3'd4
    } cfg_index_e;

    typedef struct packed {
        logic               motor_select;
        logic [COUNT_W-1:0] pulse_count;
    } in_item_t;

    typedef struct packed {
        logic                  motor_echo;
        logic [DUTY_OUT_W-1:0] duty_out;
        logic [SPEED_W-1:0]    wheel_speed;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_SPD_MUL,
        ST_ERROR,
        ST_PI_MUL,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic in_ready;
        logic mem_rw;
        logic sum_upd;
        logic spd_step;
        logic err_upd;
        logic pi_step;
        logic duty_upd;
        logic out_load;
    } ctrl_t;

endpackage

// ===== hdl/encoder_speed_pi_controller.sv =====
// Top level of the encoder speed PI controller: window store, bit-serial
// multipliers, sequencer and output register. Depends on espc_pkg.
//
// Each transfer on the input channel is one control tick for motor 0 or 1.
// The pulse count enters a WINDOW_DEPTH-entry moving-sum window kept per
// motor; the window sum times speed_scale (Q16) gives the wheel speed in
// mm/s, truncated and saturated at 65535. The error against the motor's
// target speed drives an incremental PI step, duty += kp*(e - e_prev) + ki*e,
// gains in unsigned Q8.8, duty in Q.8 clamped to 0..4000. Every tick yields
// one result: motor, integer duty and wheel speed. One tick is in work at a
// time. Its main steps are the two bit-serial shift-add multipliers, one
// multiplier bit per cycle: the speed scaling walks the SUM_W window-sum
// bits (SUM_W = 16 + clog2(WINDOW_DEPTH)) and the gain pass the 16 gain bits.
// The input side is ready again as soon as the result is parked in the output
// register, so a result waiting on out_ready stalls only the next result.
// Configuration writes are always taken (cfg_ready stays high); write them
// only while no tick is in work. Window entries carry valid bits that reset
// clears, so no clearing pass is needed after reset.
module encoder_speed_pi_controller
    import espc_pkg::*;
#(
    parameter int WINDOW_DEPTH = 5
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PTR_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W     = COUNT_W + $clog2(WINDOW_DEPTH);
    localparam int ADDR_W    = PTR_W + 1;
    localparam int MEM_DEPTH = 2 ** ADDR_W;
    localparam int PROD_W    = SCALE_W + 1 + SUM_W;
    localparam int CNT_W     = $clog2(SUM_W + 1);
    localparam int DELTA_W   = PI_HI_W + GAIN_W;
    localparam int DSUM_W    = DELTA_W + 1;

    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WINDOW_DEPTH - 1);
    localparam logic [CNT_W-1:0] SPD_LAST = CNT_W'(SUM_W - 1);
    localparam logic [CNT_W-1:0] PI_LAST  = CNT_W'(GAIN_W - 1);

    // Sequencer
    state_t state_reg;
    state_t state_next;
    ctrl_t  ctrl;

    // Configuration registers
    logic [GAIN_W-1:0]  prop_gain_reg;
    logic [GAIN_W-1:0]  integ_gain_reg;
    logic [SPEED_W-1:0] target_a_reg;
    logic [SPEED_W-1:0] target_b_reg;
    logic [SCALE_W-1:0] speed_scale_reg;

    // Per-motor state
    logic [PTR_W-1:0]         ptr_reg      [MOTOR_COUNT];
    logic [SUM_W-1:0]         sum_reg      [MOTOR_COUNT];
    logic signed [ERR_W-1:0]  prev_err_reg [MOTOR_COUNT];
    logic [DUTY_W-1:0]        duty_acc_reg [MOTOR_COUNT];

    // Window store
    logic [COUNT_W-1:0]   win_mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] win_valid_reg;
    logic [COUNT_W-1:0]   old_reg;
    logic                 old_valid_reg;

    // Tick in work
    in_item_t             item_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [SUM_W-1:0]     mul_a_reg;
    logic [SCALE_W:0]     spd_hi_reg;
    logic [SUM_W-1:0]     spd_lo_reg;
    logic [SPEED_W-1:0]   speed_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [DERR_W-1:0]  derr_reg;
    logic [GAIN_W-1:0]    kp_sh_reg;
    logic [GAIN_W-1:0]    ki_sh_reg;
    logic signed [PI_HI_W-1:0] pi_hi_reg;
    logic [GAIN_W-1:0]    pi_lo_reg;
    logic [DUTY_W-1:0]    duty_new_reg;

    // Output register
    out_item_t out_reg;
    logic      out_valid_reg;

    // Datapath nets
    logic                      m;
    logic [ADDR_W-1:0]         addr;
    logic [COUNT_W-1:0]        old_cnt;
    logic [SUM_W-1:0]          sum_new;
    logic [SCALE_W:0]          spd_add;
    logic [PROD_W-1:0]         product;
    logic [SPEED_W-1:0]        speed_sat;
    logic [SPEED_W-1:0]        target_sel;
    logic signed [ERR_W-1:0]   err_new;
    logic signed [DERR_W-1:0]  derr_new;
    logic signed [PI_HI_W-1:0] term_p;
    logic signed [PI_HI_W-1:0] term_i;
    logic signed [PI_HI_W-1:0] pi_sum;
    logic signed [DELTA_W-1:0] delta;
    logic signed [DSUM_W-1:0]  duty_sum;
    logic signed [DSUM_W-1:0]  duty_max_s;
    logic [DUTY_W-1:0]         duty_clamped;

    assign in_ready  = ctrl.in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // ---------------------------------------------------------------
    // Sequencer: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:    state_next = ST_SUM;
            ST_SUM:     state_next = ST_SPD_MUL;
            ST_SPD_MUL:
            begin
                if (cnt_reg == SPD_LAST)
                begin
                    state_next = ST_ERROR;
                end
            end
            ST_ERROR:   state_next = ST_PI_MUL;
            ST_PI_MUL:
            begin
                if (cnt_reg == PI_LAST)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:  state_next = ST_DONE;
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------
    // Sequencer: step controls
    // ---------------------------------------------------------------
    always_comb
    begin
        ctrl = '0;
        unique case (state_reg)
            ST_IDLE:    ctrl.in_ready = 1'b1;
            ST_READ:    ctrl.mem_rw   = 1'b1;
            ST_SUM:     ctrl.sum_upd  = 1'b1;
            ST_SPD_MUL: ctrl.spd_step = 1'b1;
            ST_ERROR:   ctrl.err_upd  = 1'b1;
            ST_PI_MUL:  ctrl.pi_step  = 1'b1;
            ST_UPDATE:  ctrl.duty_upd = 1'b1;
            ST_DONE:    ctrl.out_load = !out_valid_reg || out_ready;
            default:    ctrl = '0;
        endcase
    end

    // ---------------------------------------------------------------
    // Datapath
    // ---------------------------------------------------------------
    assign m    = item_reg.motor_select;
    assign addr = {m, ptr_reg[m]};

    // Drop the oldest count and add the new one
    assign old_cnt = old_valid_reg ? old_reg : '0;
    assign sum_new = sum_reg[m] - SUM_W'(old_cnt) + SUM_W'(item_reg.pulse_count);

    // Speed scaling: LSB-first shift-add, one window-sum bit per cycle
    assign spd_add = spd_hi_reg + (mul_a_reg[0] ? {1'b0, speed_scale_reg} : '0);
    assign product = {spd_hi_reg, spd_lo_reg};
    assign speed_sat = (|product[PROD_W-1:32]) ? SPEED_MAX : product[31:16];

    assign target_sel = m ? target_b_reg : target_a_reg;
    assign err_new    = signed'({2'b00, target_sel}) - signed'({2'b00, speed_sat});
    assign derr_new   = signed'({err_new[ERR_W-1], err_new})
                      - signed'({prev_err_reg[m][ERR_W-1], prev_err_reg[m]});

    // Gain pass: both products share one accumulator, one gain bit per cycle
    assign term_p = kp_sh_reg[0]
                  ? signed'({{(PI_HI_W-DERR_W){derr_reg[DERR_W-1]}}, derr_reg}) : '0;
    assign term_i = ki_sh_reg[0]
                  ? signed'({{(PI_HI_W-ERR_W){err_reg[ERR_W-1]}}, err_reg}) : '0;
    assign pi_sum = pi_hi_reg + term_p + term_i;

    assign delta      = signed'({pi_hi_reg, pi_lo_reg});
    assign duty_max_s = signed'({{(DSUM_W-DUTY_W){1'b0}}, DUTY_MAX_Q8});
    assign duty_sum   = signed'({{(DSUM_W-DUTY_W){1'b0}}, duty_acc_reg[m]})
                      + signed'({delta[DELTA_W-1], delta});

    always_comb
    begin
        if (duty_sum[DSUM_W-1])
        begin
            duty_clamped = '0;
        end
        else if (duty_sum > duty_max_s)
        begin
            duty_clamped = DUTY_MAX_Q8;
        end
        else
        begin
            duty_clamped = duty_sum[DUTY_W-1:0];
        end
    end

    // ---------------------------------------------------------------
    // Control state, configuration and per-motor state
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            out_valid_reg   <= 1'b0;
            prop_gain_reg   <= PROP_GAIN_RST;
            integ_gain_reg  <= INTEG_GAIN_RST;
            target_a_reg    <= '0;
            target_b_reg    <= '0;
            speed_scale_reg <= SPEED_SCALE_RST;
            win_valid_reg   <= '0;
            for (int i = 0; i < MOTOR_COUNT; i++)
            begin
                ptr_reg[i]      <= '0;
                sum_reg[i]      <= '0;
                prev_err_reg[i] <= '0;
                duty_acc_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_PROP_GAIN:      prop_gain_reg   <= cfg_data[GAIN_W-1:0];
                    CFG_INTEG_GAIN:     integ_gain_reg  <= cfg_data[GAIN_W-1:0];
                    CFG_TARGET_SPEED_A: target_a_reg    <= cfg_data[SPEED_W-1:0];
                    CFG_TARGET_SPEED_B: target_b_reg    <= cfg_data[SPEED_W-1:0];
                    CFG_SPEED_SCALE:    speed_scale_reg <= cfg_data[SCALE_W-1:0];
                    default:            ;
                endcase
            end

            if (ctrl.mem_rw)
            begin
                win_valid_reg[addr] <= 1'b1;
            end

            // Advance the window pointer and hold the new sum
            if (ctrl.sum_upd)
            begin
                sum_reg[m] <= sum_new;
                ptr_reg[m] <= (ptr_reg[m] == PTR_LAST) ? '0 : ptr_reg[m] + 1'b1;
            end

            if (ctrl.duty_upd)
            begin
                duty_acc_reg[m] <= duty_clamped;
                prev_err_reg[m] <= err_reg;
            end

            if (ctrl.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // Window store: read the oldest count, overwrite it with the new one
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (ctrl.mem_rw)
        begin
            old_reg       <= win_mem[addr];
            win_mem[addr] <= item_reg.pulse_count;
        end
    end

    // ---------------------------------------------------------------
    // Payload registers of the tick in work
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (in_valid && ctrl.in_ready)
        begin
            item_reg <= in_data;
        end

        if (ctrl.mem_rw)
        begin
            old_valid_reg <= win_valid_reg[addr];
        end

        if (ctrl.sum_upd)
        begin
            mul_a_reg  <= sum_new;
            spd_hi_reg <= '0;
            spd_lo_reg <= '0;
            cnt_reg    <= '0;
        end

        if (ctrl.spd_step)
        begin
            mul_a_reg  <= mul_a_reg >> 1;
            spd_hi_reg <= spd_add >> 1;
            spd_lo_reg <= {spd_add[0], spd_lo_reg[SUM_W-1:1]};
            cnt_reg    <= cnt_reg + 1'b1;
        end

        if (ctrl.err_upd)
        begin
            speed_reg <= speed_sat;
            err_reg   <= err_new;
            derr_reg  <= derr_new;
            kp_sh_reg <= prop_gain_reg;
            ki_sh_reg <= integ_gain_reg;
            pi_hi_reg <= '0;
            pi_lo_reg <= '0;
            cnt_reg   <= '0;
        end

        if (ctrl.pi_step)
        begin
            kp_sh_reg <= kp_sh_reg >> 1;
            ki_sh_reg <= ki_sh_reg >> 1;
            pi_hi_reg <= pi_sum >>> 1;
            pi_lo_reg <= {pi_sum[0], pi_lo_reg[GAIN_W-1:1]};
            cnt_reg   <= cnt_reg + 1'b1;
        end

        if (ctrl.duty_upd)
        begin
            duty_new_reg <= duty_clamped;
        end

        if (ctrl.out_load)
        begin
            out_reg.motor_echo  <= m;
            out_reg.duty_out    <= duty_new_reg[DUTY_W-1:DUTY_FRAC_W];
            out_reg.wheel_speed <= speed_reg;
        end
    end

endmodule

// ===== hdl/espc_checker.sv =====
// Port-level checks for the encoder speed PI controller, bound to the top
// level. Depends on espc_pkg and encoder_speed_pi_controller.
module espc_checker
    import espc_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  in_valid,
    input logic                  in_ready,
    input logic                  out_valid,
    input logic                  out_ready,
    input out_item_t             out_data
);

    // Hold a stalled result
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed or dropped");

    // A tick in work blocks the next one
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while a tick is in work");

    // A result never appears right after a transfer in
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared too early");

    // Duty stays within the clamp
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.duty_out <= DUTY_LIMIT)
        else $error("duty out of range");

endmodule

bind encoder_speed_pi_controller espc_checker u_espc_checker (.*);

// ===== sim/testbench.sv =====
// Self-checking testbench for encoder_speed_pi_controller: directed and random
// control ticks, checked against a cycle-free predictor of the PI step.
// Depends on espc_pkg and the RTL top level only.
module testbench;
    import espc_pkg::*;

    localparam int WINDOW_LEN    = 5;
    localparam int SETTLE_CYCLES = 64;
    localparam int LONG_HOLD     = 400;      // output hold, in cycles
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TICKS   = 125;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_item_t              in_data;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Register copies, updated on each config transfer.
    logic [GAIN_W-1:0]  prop_gain;
    logic [GAIN_W-1:0]  integ_gain;
    logic [SPEED_W-1:0] target_speed [MOTOR_COUNT];
    logic [SCALE_W-1:0] speed_scale;

    // Per-motor controller state as the predictor sees it.
    logic [COUNT_W-1:0] window_counts [MOTOR_COUNT][WINDOW_LEN];
    longint             window_total  [MOTOR_COUNT];
    int                 window_slot   [MOTOR_COUNT];
    longint             last_error    [MOTOR_COUNT];
    longint             duty_q8       [MOTOR_COUNT];

    out_item_t awaited_results[$];

    int fail_count      = 0;
    int ticks_sent      = 0;
    int results_checked = 0;
    int settings_used   = 0;
    int cycle_count     = 0;

    // Sender idling: bursts of random length separated by random gaps.
    bit gaps_on    = 1'b1;
    int burst_left = 0;

    // Receiver: a request counter owned by the test, served by the receiver.
    int             hold_requests = 0;
    int             hold_served   = 0;
    int             hold_left     = 0;
    logic [15:0]    ready_pattern = '1;
    logic [3:0]     pattern_phase = '0;

    encoder_speed_pi_controller #(
        .WINDOW_DEPTH(WINDOW_LEN)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Advance the controller state by one tick and return the result it owes.
    function automatic out_item_t step_controller(in_item_t tick);
        int        m;
        int        slot;
        longint    speed;
        longint    err;
        longint    duty;
        out_item_t res;
        m = int'(tick.motor_select);
        slot = window_slot[m];
        // Replace the oldest count of the window and keep the running sum.
        window_total[m] = window_total[m] - longint'(window_counts[m][slot])
                        + longint'(tick.pulse_count);
        window_counts[m][slot] = tick.pulse_count;
        window_slot[m] = (slot + 1) % WINDOW_LEN;
        // Q16 scale, truncate, then saturate.
        speed = (window_total[m] * longint'(speed_scale)) >>> 16;
        if (speed > longint'(SPEED_MAX))
            speed = longint'(SPEED_MAX);
        err = longint'(target_speed[m]) - speed;
        // Incremental PI step in Q.8, clamped to 0..4000.0.
        duty = duty_q8[m] + longint'(prop_gain) * (err - last_error[m])
             + longint'(integ_gain) * err;
        if (duty > longint'(DUTY_MAX_Q8))
            duty = longint'(DUTY_MAX_Q8);
        if (duty < 0)
            duty = 0;
        duty_q8[m] = duty;
        last_error[m] = err;
        res.motor_echo  = tick.motor_select;
        res.duty_out    = DUTY_OUT_W'(duty >>> DUTY_FRAC_W);
        res.wheel_speed = SPEED_W'(speed);
        return res;
    endfunction

    // Sample both channels at the rising edge: check each output transfer
    // against the oldest expectation, predict on each input transfer and
    // track register writes.
    always @(posedge clk)
    begin
        out_item_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, awaited_results.size());
            $display("TB_ERROR");
            $finish;
        end
        else if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (awaited_results.size() == 0)
                begin
                    $error("result with no tick outstanding: motor %0d duty %0d speed %0d",
                           out_data.motor_echo, out_data.duty_out, out_data.wheel_speed);
                    fail_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    results_checked++;
                    if (out_data.motor_echo !== want.motor_echo)
                    begin
                        $error("motor_echo: expected %0d, got %0d",
                               want.motor_echo, out_data.motor_echo);
                        fail_count++;
                    end
                    if (out_data.duty_out !== want.duty_out)
                    begin
                        $error("duty_out: expected %0d, got %0d",
                               want.duty_out, out_data.duty_out);
                        fail_count++;
                    end
                    if (out_data.wheel_speed !== want.wheel_speed)
                    begin
                        $error("wheel_speed: expected %0d, got %0d",
                               want.wheel_speed, out_data.wheel_speed);
                        fail_count++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                awaited_results.push_back(step_controller(in_data));
                ticks_sent++;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_PROP_GAIN:      prop_gain       = cfg_data[GAIN_W-1:0];
                    CFG_INTEG_GAIN:     integ_gain      = cfg_data[GAIN_W-1:0];
                    CFG_TARGET_SPEED_A: target_speed[0] = cfg_data[SPEED_W-1:0];
                    CFG_TARGET_SPEED_B: target_speed[1] = cfg_data[SPEED_W-1:0];
                    CFG_SPEED_SCALE:    speed_scale     = cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Receiver: drive out_ready at the falling edge. A pending hold request
    // forces a long stall; otherwise walk a 16-bit pattern that is redrawn
    // each lap as all-ready, mostly-ready or mostly-stalled.
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_left = LONG_HOLD;
            hold_served = hold_requests;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready = 1'b0;
        end
        else
        begin
            if (pattern_phase == 4'd0)
            begin
                case ($urandom_range(0, 3))
                    0:       ready_pattern = '1;
                    1:       ready_pattern = 16'($urandom) & 16'($urandom);
                    default: ready_pattern = 16'($urandom) | 16'($urandom);
                endcase
            end
            out_ready = ready_pattern[pattern_phase];
            pattern_phase = pattern_phase + 4'd1;
        end
    end

    // Offer one tick; hold valid and payload until the transfer happens.
    // Leaves valid high so the next call can follow back to back.
    task automatic send_tick(input logic motor, input logic [COUNT_W-1:0] count);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 48);
            burst_left = $urandom_range(1, 24);
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        if (burst_left > 0)
            burst_left--;
        @(negedge clk);
        in_valid = 1'b1;
        in_data.motor_select = motor;
        in_data.pulse_count = count;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    // Drop valid, wait for every outstanding result, then let the block settle.
    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input cfg_index_e idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic write_settings(input logic [GAIN_W-1:0] kp,
                                  input logic [GAIN_W-1:0] ki,
                                  input logic [SPEED_W-1:0] goal_a,
                                  input logic [SPEED_W-1:0] goal_b,
                                  input logic [SCALE_W-1:0] scale);
        write_register(CFG_PROP_GAIN, CFG_DATA_W'(kp));
        write_register(CFG_INTEG_GAIN, CFG_DATA_W'(ki));
        write_register(CFG_TARGET_SPEED_A, CFG_DATA_W'(goal_a));
        write_register(CFG_TARGET_SPEED_B, CFG_DATA_W'(goal_b));
        write_register(CFG_SPEED_SCALE, CFG_DATA_W'(scale));
        settings_used++;
    endtask

    // Mostly small counts so speed lands near the target, with some full range
    // and the two extremes.
    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 19))
            0, 1, 2:    return COUNT_W'($urandom);
            3:          return '0;
            4:          return '1;
            5, 6, 7, 8: return COUNT_W'($urandom_range(0, 4095));
            default:    return COUNT_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [GAIN_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return GAIN_W'($urandom);
            default: return GAIN_W'($urandom_range(1, 1023));
        endcase
    endfunction

    function automatic logic [SPEED_W-1:0] pick_target();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return SPEED_W'($urandom);
            default: return SPEED_W'($urandom_range(0, 3000));
        endcase
    endfunction

    function automatic logic [SCALE_W-1:0] pick_scale();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return SCALE_W'($urandom);
            default: return SCALE_W'($urandom_range(4096, 262144));
        endcase
    endfunction

    // Reset values: targets are zero, so the duty must stay at zero.
    task automatic test_reset_values();
        send_tick(1'b0, 16'd0);
        send_tick(1'b1, 16'hFFFF);
        send_tick(1'b0, 16'hFFFF);
        drain_results();
    endtask

    // Register and field extremes: scale zero drives motor 0's error to its top
    // and its duty into the upper clamp; full scale saturates the speed, drives
    // motor 0's error to its bottom and its duty into the lower clamp.
    task automatic test_extremes();
        write_settings('1, '1, '1, '0, '0);
        send_tick(1'b0, 16'hFFFF);
        send_tick(1'b1, 16'hFFFF);
        send_tick(1'b0, 16'd0);
        send_tick(1'b1, 16'd0);
        drain_results();
        write_settings('0, '1, '0, '1, '1);
        send_tick(1'b0, 16'hFFFF);
        send_tick(1'b1, 16'hFFFF);
        send_tick(1'b0, 16'd1);
        send_tick(1'b1, 16'd1);
        drain_results();
    endtask

    // Scale of 1.5 on odd counts exercises truncation of the speed wherever a
    // window sum is odd; twelve ticks wrap each motor's window past its depth.
    task automatic test_rounding_and_wrap();
        write_settings(PROP_GAIN_RST, INTEG_GAIN_RST, 16'd300, 16'd200, 24'h018000);
        for (int i = 0; i < 12; i++)
            send_tick(1'(i % 2), COUNT_W'(2 * i + 1));
        drain_results();
    endtask

    // Stall the output for a long stretch while ticks keep coming back to
    // back, so the block fills and holds off its input.
    task automatic test_output_hold();
        write_settings(pick_gain(), pick_gain(), pick_target(), pick_target(),
                       pick_scale());
        gaps_on = 1'b0;
        hold_requests++;
        for (int i = 0; i < 12; i++)
            send_tick(1'($urandom), pick_count());
        drain_results();
        gaps_on = 1'b1;
    endtask

    // Random phases, each with fresh register values; halfway through each
    // phase the sender pauses until every result is back.
    task automatic test_random_ticks();
        logic motor;
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_settings(pick_gain(), pick_gain(), pick_target(), pick_target(),
                           pick_scale());
            motor = 1'($urandom);
            for (int i = 0; i < PHASE_TICKS; i++)
            begin
                // Mostly alternate motors, with runs on one motor now and then.
                if ($urandom_range(0, 3) != 0)
                    motor = ~motor;
                send_tick(motor, pick_count());
                if (i == PHASE_TICKS / 2)
                    drain_results();
            end
            drain_results();
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        prop_gain = PROP_GAIN_RST;
        integ_gain = INTEG_GAIN_RST;
        target_speed[0] = '0;
        target_speed[1] = '0;
        speed_scale = SPEED_SCALE_RST;
        for (int m = 0; m < MOTOR_COUNT; m++)
        begin
            for (int s = 0; s < WINDOW_LEN; s++)
                window_counts[m][s] = '0;
            window_total[m] = 0;
            window_slot[m] = 0;
            last_error[m] = 0;
            duty_q8[m] = 0;
        end
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_extremes();
        test_rounding_and_wrap();
        test_output_hold();
        test_random_ticks();

        $display("covered %0d ticks under %0d register settings, %0d results compared",
                 ticks_sent, settings_used, results_checked);
        $display("including clamps, speed saturation and a %0d-cycle output hold",
                 LONG_HOLD);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
